// ===== rtl/core/bscp_pkg.sv =====
// Shared types, codes and defaults for the buffered serial console port.
package bscp_pkg;

   localparam int DEFAULT_BUFFER_DEPTH = 32;

   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_TERM  = 2'd2;

   localparam logic [2:0] ADDR_STATUS   = 3'd2;
   localparam logic [2:0] ADDR_OUTBOUND = 3'd3;
   localparam logic [2:0] ADDR_FLUSH    = 3'd4;
   localparam logic [2:0] ADDR_CONFIG   = 3'd5;
   localparam logic [2:0] ADDR_INBOUND  = 3'd6;

   localparam logic [2:0] LEN_BYTE = 3'd1;

   localparam logic [1:0] IRQ_NONE    = 2'd0;
   localparam logic [1:0] IRQ_RECEIVE = 2'd1;
   localparam logic [1:0] IRQ_FLUSH   = 2'd2;

   localparam logic KIND_ACCESS = 1'b0;
   localparam logic KIND_BYTE   = 1'b1;

   localparam logic [1:0] CSR_IRQ_ON_FLUSH   = 2'd0;
   localparam logic [1:0] CSR_AUTO_FLUSH     = 2'd1;
   localparam logic [1:0] CSR_IRQ_ON_RECEIVE = 2'd2;

   typedef struct packed {
      logic [1:0] command;
      logic [2:0] reg_address;
      logic [2:0] access_length;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic       result_kind;
      logic [7:0] read_byte;
      logic [7:0] out_byte;
      logic [3:0] status_bits;
      logic [1:0] irq_code;
      logic       last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DRAIN,
      ST_FINISH,
      ST_RESP
   } state_type;

endpackage

// ===== rtl/core/bscp_buffer.sv =====
// Outbound byte buffer: one write port and one registered read port.
module bscp_buffer
   import bscp_pkg::*;
#(
   parameter int DEPTH = DEFAULT_BUFFER_DEPTH,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/buffered_serial_console_port.sv =====
// Top level of the buffered serial console port: register decode, drain sequencer, results.
//
// An item is taken when start is high and busy is low. Reads, terminal bytes, config
// writes, dropped writes and outbound writes without a drain are answered from the
// execute state, and a new item can start right after. An item that drains buffered
// bytes passes the drain, finish and response states; the buffer memory gives one byte
// per cycle through its single registered read port. An empty flush skips the drain.
// Results are strobed on rsp_valid for exactly one cycle each and cannot be held off;
// drained bytes come first, oldest first, and the access response with last set ends
// every item.
module buffered_serial_console_port
   import bscp_pkg::*;
#(
   parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_item,
   output logic       rsp_valid,
   output rsp_type    rsp_item,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic       csr_data
);

   localparam int FW = $clog2(BUFFER_DEPTH + 1);
   localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

   state_type     state_ff, state_in;
   req_type       req_ff, req_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [7:0]    inbound_ff, inbound_in;
   logic          ready_ff, ready_in;
   logic          missed_ff, missed_in;
   logic          irq_on_flush_ff, irq_on_flush_in;
   logic          auto_flush_ff, auto_flush_in;
   logic          irq_on_receive_ff, irq_on_receive_in;
   logic [1:0]    irq_ff, irq_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic [AW-1:0] last_idx_ff, last_idx_in;
   logic          rd_valid_ff, rd_valid_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          wr_en;
   logic          rd_en;
   logic [7:0]    rd_data;
   logic [FW-1:0] fill_dec;
   logic [3:0]    status_now;
   logic [3:0]    status_next;
   logic          is_byte_op;

   bscp_buffer #(
      .DEPTH (BUFFER_DEPTH),
      .AW    (AW)
   ) u_buffer (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[AW-1:0]),
      .wr_data (req_ff.data_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   assign fill_dec   = fill_ff - FW'(1);
   assign is_byte_op = (req_ff.access_length == LEN_BYTE);

   assign status_now  = {missed_ff, ready_ff, (fill_ff >= FW'(BUFFER_DEPTH)), (fill_ff != '0)};
   assign status_next = {missed_in, ready_in, (fill_in >= FW'(BUFFER_DEPTH)), (fill_in != '0)};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         fill_ff           <= '0;
         inbound_ff        <= '0;
         ready_ff          <= 1'b0;
         missed_ff         <= 1'b0;
         irq_on_flush_ff   <= 1'b0;
         auto_flush_ff     <= 1'b0;
         irq_on_receive_ff <= 1'b1;
         rd_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         fill_ff           <= fill_in;
         inbound_ff        <= inbound_in;
         ready_ff          <= ready_in;
         missed_ff         <= missed_in;
         irq_on_flush_ff   <= irq_on_flush_in;
         auto_flush_ff     <= auto_flush_in;
         irq_on_receive_ff <= irq_on_receive_in;
         rd_valid_ff       <= rd_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      irq_ff      <= irq_in;
      rd_idx_ff   <= rd_idx_in;
      last_idx_ff <= last_idx_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      state_in          = state_ff;
      req_in            = req_ff;
      fill_in           = fill_ff;
      inbound_in        = inbound_ff;
      ready_in          = ready_ff;
      missed_in         = missed_ff;
      irq_on_flush_in   = irq_on_flush_ff;
      auto_flush_in     = auto_flush_ff;
      irq_on_receive_in = irq_on_receive_ff;
      irq_in            = irq_ff;
      rd_idx_in         = rd_idx_ff;
      last_idx_in       = last_idx_ff;
      rd_valid_in       = 1'b0;
      rsp_valid_in      = 1'b0;
      rsp_in            = '0;
      wr_en             = 1'b0;
      rd_en             = 1'b0;

      if (csr_valid) begin
         case (csr_index)
            CSR_IRQ_ON_FLUSH:   irq_on_flush_in   = csr_data;
            CSR_AUTO_FLUSH:     auto_flush_in     = csr_data;
            CSR_IRQ_ON_RECEIVE: irq_on_receive_in = csr_data;
            default: ;
         endcase
      end

      if (rd_valid_ff) begin
         rsp_valid_in       = 1'b1;
         rsp_in.result_kind = KIND_BYTE;
         rsp_in.out_byte    = rd_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_item;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            logic       drain;
            logic [7:0] rd_byte;
            drain   = 1'b0;
            rd_byte = 8'd0;
            irq_in  = IRQ_NONE;
            case (req_ff.command)
               CMD_TERM: begin
                  inbound_in = req_ff.data_byte;
                  missed_in  = missed_ff | ready_ff;
                  ready_in   = 1'b1;
                  if (irq_on_receive_ff) begin
                     irq_in = IRQ_RECEIVE;
                  end
               end
               CMD_READ: begin
                  if (is_byte_op && req_ff.reg_address == ADDR_STATUS) begin
                     rd_byte = {4'd0, status_now};
                  end else if (is_byte_op && req_ff.reg_address == ADDR_INBOUND) begin
                     rd_byte   = inbound_ff;
                     ready_in  = 1'b0;
                     missed_in = 1'b0;
                  end
               end
               CMD_WRITE: begin
                  if (is_byte_op && req_ff.reg_address == ADDR_OUTBOUND) begin
                     if (fill_ff < FW'(BUFFER_DEPTH)) begin
                        wr_en       = 1'b1;
                        fill_in     = fill_ff + FW'(1);
                        last_idx_in = fill_ff[AW-1:0];
                        drain       = auto_flush_ff;
                     end
                  end else if (is_byte_op && req_ff.reg_address == ADDR_FLUSH) begin
                     last_idx_in = fill_dec[AW-1:0];
                     drain       = 1'b1;
                  end else if (is_byte_op && req_ff.reg_address == ADDR_CONFIG) begin
                     irq_on_flush_in   = req_ff.data_byte[0];
                     auto_flush_in     = req_ff.data_byte[1];
                     irq_on_receive_in = req_ff.data_byte[2];
                  end
               end
               default: ;
            endcase
            if (drain) begin
               if (irq_on_flush_ff) begin
                  irq_in = IRQ_FLUSH;
               end
               rd_idx_in = '0;
               fill_in   = '0;
               if (wr_en || fill_ff != '0) begin
                  state_in = ST_DRAIN;
               end else begin
                  state_in = ST_RESP;
               end
            end else begin
               rsp_valid_in       = 1'b1;
               rsp_in.result_kind = KIND_ACCESS;
               rsp_in.read_byte   = rd_byte;
               rsp_in.status_bits = status_next;
               rsp_in.irq_code    = irq_in;
               rsp_in.last        = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         ST_DRAIN: begin
            rd_en       = 1'b1;
            rd_valid_in = 1'b1;
            if (rd_idx_ff == last_idx_ff) begin
               state_in = ST_FINISH;
            end else begin
               rd_idx_in = rd_idx_ff + AW'(1);
            end
         end
         ST_FINISH: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid_in       = 1'b1;
            rsp_in.result_kind = KIND_ACCESS;
            rsp_in.status_bits = status_now;
            rsp_in.irq_code    = irq_ff;
            rsp_in.last        = 1'b1;
            state_in           = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ===== rtl/core/bscp_checker.sv =====
// Port-level checks for the buffered serial console port, bound to the top level.
module bscp_checker
   import bscp_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_item
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("An accepted item did not make the port busy.");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.last |-> !busy)
      else $error("The final result of an item came while the port was still busy.");

   a_byte_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.result_kind == KIND_BYTE |->
         busy && !rsp_item.last && rsp_item.status_bits == 4'd0
         && rsp_item.irq_code == IRQ_NONE)
      else $error("A drained byte result is malformed or came outside a drain.");

   a_access_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.result_kind == KIND_ACCESS |->
         rsp_item.last && (!rsp_item.status_bits[1] || rsp_item.status_bits[0]))
      else $error("An access response is not last or reports full while empty.");

endmodule

bind buffered_serial_console_port bscp_checker u_bscp_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
